@@ rtl/pfs_pkg.sv @@
// ----------------------------------------------------------------------------
// pfs_pkg
// Shared types and constants of the potentiometer to rpm setpoint filter.
// ----------------------------------------------------------------------------
package pfs_pkg;

   localparam int ADC_W    = 12;
   localparam int ALPHA_W  = 9;
   localparam int RPM_W    = 16;
   localparam int FREQ_W   = 19;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // serial divider: dividend and divisor widths
   localparam int DVD_W    = 28;
   localparam int DVS_W    = 12;
   localparam int DIV_CNT_W = $clog2(DVD_W);

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // rpm * 256 / 60 by reciprocal multiplication
   localparam int     RPM_PER_HZ      = 60;
   localparam int     FREQ_DIV_SHIFT  = RPM_W + 8 + $clog2(RPM_PER_HZ);
   localparam int     FREQ_PROD_SHIFT = FREQ_DIV_SHIFT - 8;
   localparam longint FREQ_RECIP      = ((longint'(1) << FREQ_DIV_SHIFT)
                                         + longint'(RPM_PER_HZ) - 1)
                                        / longint'(RPM_PER_HZ);
   localparam int     FREQ_RECIP_W    = $clog2(FREQ_RECIP + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_DEADZONE        = 3'd0,
      REG_ZERO_SNAP       = 3'd1,
      REG_SMOOTHING_ALPHA = 3'd2,
      REG_ADC_FULL_SCALE  = 3'd3,
      REG_MIN_RPM         = 3'd4,
      REG_MAX_RPM         = 3'd5,
      REG_RPM_DEADBAND    = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [ADC_W-1:0]   deadzone;
      logic [ADC_W-1:0]   zero_snap;
      logic [ALPHA_W-1:0] smoothing_alpha;
      logic [ADC_W-1:0]   adc_full_scale;
      logic [RPM_W-1:0]   min_rpm;
      logic [RPM_W-1:0]   max_rpm;
      logic [RPM_W-1:0]   rpm_deadband;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      deadzone:        ADC_W'(50),
      zero_snap:       ADC_W'(5),
      smoothing_alpha: ALPHA_W'(51),
      adc_full_scale:  ADC_W'(4095),
      min_rpm:         RPM_W'(0),
      max_rpm:         RPM_W'(3000),
      rpm_deadband:    RPM_W'(10)
   };

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ rtl/pfs_fifo.sv @@
// ----------------------------------------------------------------------------
// pfs_fifo
// Short queue carrying completed block sums from the front to the back.
// ----------------------------------------------------------------------------
module pfs_fifo
   import pfs_pkg::*;
#(
   parameter int WIDTH = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0]  entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/pfs_front.sv @@
// ----------------------------------------------------------------------------
// pfs_front
// Accepts samples, sums them per block and queues each completed block sum.
// ----------------------------------------------------------------------------
module pfs_front
   import pfs_pkg::*;
#(
   parameter int SAMPLE_COUNT = 16,
   parameter int SUM_W        = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [ADC_W-1:0] req_sample,
   output logic             push,
   output logic [SUM_W-1:0] push_data,
   input  logic             full
);

   localparam int CNT_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             last;
   logic             accept;
   logic [SUM_W-1:0] sum_next;

   assign last      = (cnt_ff == CNT_W'(SAMPLE_COUNT - 1));
   assign req_stall = last && full;
   assign accept    = req_valid && !req_stall;
   assign sum_next  = sum_ff + SUM_W'(req_sample);
   assign push      = accept && last;
   assign push_data = sum_next;

   always_comb begin
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         if (last) begin
            sum_in = '0;
            cnt_in = '0;
         end else begin
            sum_in = sum_next;
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

@@ rtl/pfs_div.sv @@
// ----------------------------------------------------------------------------
// pfs_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfs_div
   import pfs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0]     quo_ff, quo_in;
   logic [DVS_W-1:0]     rem_ff, rem_in;
   logic [DVS_W-1:0]     dvs_ff, dvs_in;
   logic [DVS_W:0]       shifted;
   logic [DVS_W:0]       diff;
   logic                 fits;

   assign shifted = {rem_ff, quo_ff[DVD_W-1]};
   assign fits    = (shifted >= {1'b0, dvs_ff});
   assign diff    = shifted - {1'b0, dvs_ff};

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], fits};
         rem_in = fits ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

@@ rtl/pfs_back.sv @@
// ----------------------------------------------------------------------------
// pfs_back
// Sequencer that turns each block sum into the filtered level, rpm setpoint
// and frequency, using the serial divider for the mapping, and holds the
// result.
// ----------------------------------------------------------------------------
module pfs_back
   import pfs_pkg::*;
#(
   parameter int SAMPLE_COUNT = 16,
   parameter int SUM_W        = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic [SUM_W-1:0]  q_data,
   input  logic              q_empty,
   output logic              q_pop,
   output div_req_type       div_req,
   input  div_rsp_type       div_rsp,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [RPM_W-1:0]  rsp_rpm,
   output logic [FREQ_W-1:0] rsp_frequency_q8
);

   localparam int FILT_W  = 20;
   localparam int LEVEL_W = 13;
   localparam int PROD_W  = FILT_W + ALPHA_W;

   // block average by reciprocal multiplication, exact for every block sum
   localparam int     AVG_SHIFT = SUM_W + $clog2(SAMPLE_COUNT);
   localparam longint AVG_RECIP = ((longint'(1) << AVG_SHIFT)
                                   + longint'(SAMPLE_COUNT) - 1)
                                  / longint'(SAMPLE_COUNT);

   typedef enum logic [9:0] {
      S_IDLE    = 10'b0000000001,
      S_AVG     = 10'b0000000010,
      S_SNAP    = 10'b0000000100,
      S_EMA     = 10'b0000001000,
      S_LEVEL   = 10'b0000010000,
      S_MAP     = 10'b0000100000,
      S_MAPDIV  = 10'b0001000000,
      S_HYST    = 10'b0010000000,
      S_FREQ    = 10'b0100000000,
      S_OUT     = 10'b1000000000
   } state_type;

   state_type           state_ff, state_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [ADC_W-1:0]    avg_ff, avg_in;
   logic [FILT_W-1:0]   filt_ff, filt_in;
   logic [RPM_W-1:0]    cur_ff, cur_in;
   logic [PROD_W-1:0]   prod_a_ff, prod_a_in;
   logic [PROD_W-1:0]   prod_b_ff, prod_b_in;
   logic [DVD_W-1:0]    num_ff, num_in;
   logic                neg_ff, neg_in;
   logic [RPM_W-1:0]    mapped_ff, mapped_in;
   logic [FREQ_W-1:0]   freq_ff, freq_in;
   logic                out_valid_ff, out_valid_in;
   logic [RPM_W-1:0]    out_rpm_ff, out_rpm_in;
   logic [FREQ_W-1:0]   out_freq_ff, out_freq_in;

   logic [2*SUM_W:0]    avg_prod;
   logic [ADC_W-1:0]    avg_raw;
   logic [RPM_W+FREQ_RECIP_W-1:0] freq_prod;
   logic [ALPHA_W-1:0]  alpha;
   logic [ALPHA_W-1:0]  alpha_inv;
   logic [PROD_W:0]     acc;
   logic [FILT_W:0]     level_wide;
   logic [LEVEL_W-1:0]  level;
   logic [LEVEL_W-1:0]  level_ofs;
   logic [RPM_W-1:0]    span;
   logic [LEVEL_W+RPM_W-1:0] num_wide;
   logic [DVD_W:0]      x_wide;
   logic [RPM_W-1:0]    diff;

   assign rsp_valid        = out_valid_ff;
   assign rsp_rpm          = out_rpm_ff;
   assign rsp_frequency_q8 = out_freq_ff;

   assign avg_prod  = sum_ff * (SUM_W+1)'(AVG_RECIP);
   assign avg_raw   = avg_prod[AVG_SHIFT +: ADC_W];
   assign freq_prod = cur_ff * FREQ_RECIP_W'(FREQ_RECIP);
   assign alpha     = (cfg.smoothing_alpha > ALPHA_W'(256)) ? ALPHA_W'(256)
                                                            : cfg.smoothing_alpha;
   assign alpha_inv = ALPHA_W'(256) - alpha;
   assign acc       = (PROD_W+1)'(prod_a_ff) + (PROD_W+1)'(prod_b_ff)
                      + (PROD_W+1)'(128);
   assign level_wide = (FILT_W+1)'(filt_ff) + (FILT_W+1)'(128);
   assign level     = level_wide[FILT_W:8];
   assign level_ofs = level - LEVEL_W'(cfg.deadzone);
   assign span      = (cfg.max_rpm >= cfg.min_rpm) ? (cfg.max_rpm - cfg.min_rpm)
                                                   : (cfg.min_rpm - cfg.max_rpm);
   assign num_wide  = level_ofs * span;
   assign x_wide    = (DVD_W+1)'(cfg.min_rpm) + (DVD_W+1)'(div_rsp.quotient);
   assign diff      = (mapped_ff >= cur_ff) ? (mapped_ff - cur_ff) : (cur_ff - mapped_ff);

   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      avg_in       = avg_ff;
      filt_in      = filt_ff;
      cur_in       = cur_ff;
      prod_a_in    = prod_a_ff;
      prod_b_in    = prod_b_ff;
      num_in       = num_ff;
      neg_in       = neg_ff;
      mapped_in    = mapped_ff;
      freq_in      = freq_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_rpm_in   = out_rpm_ff;
      out_freq_in  = out_freq_ff;
      q_pop        = 1'b0;
      div_req      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               sum_in   = q_data;
               state_in = S_AVG;
            end
         end
         S_AVG: begin
            avg_in   = (avg_raw <= cfg.deadzone) ? '0 : avg_raw;
            state_in = S_SNAP;
         end
         S_SNAP: begin
            if (avg_ff == '0 && filt_ff <= {cfg.zero_snap, 8'b0}) begin
               filt_in  = '0;
               state_in = S_LEVEL;
            end else begin
               prod_a_in = filt_ff * alpha_inv;
               prod_b_in = {avg_ff, 8'b0} * alpha;
               state_in  = S_EMA;
            end
         end
         S_EMA: begin
            filt_in  = acc[FILT_W+7:8];
            state_in = S_LEVEL;
         end
         S_LEVEL: begin
            if (level <= LEVEL_W'(cfg.deadzone)) begin
               cur_in   = '0;
               state_in = S_FREQ;
            end else if (cfg.adc_full_scale <= cfg.deadzone) begin
               mapped_in = cfg.max_rpm;
               state_in  = S_HYST;
            end else begin
               num_in   = num_wide[DVD_W-1:0];
               neg_in   = (cfg.min_rpm > cfg.max_rpm);
               state_in = S_MAP;
            end
         end
         S_MAP: begin
            div_req.start    = 1'b1;
            div_req.dividend = num_ff;
            div_req.divisor  = cfg.adc_full_scale - cfg.deadzone;
            state_in         = S_MAPDIV;
         end
         S_MAPDIV: begin
            if (div_rsp.done) begin
               if (neg_ff && div_rsp.quotient != '0) begin
                  mapped_in = cfg.min_rpm;
               end else if (x_wide > (DVD_W+1)'(cfg.max_rpm)) begin
                  mapped_in = cfg.max_rpm;
               end else begin
                  mapped_in = x_wide[RPM_W-1:0];
               end
               state_in = S_HYST;
            end
         end
         S_HYST: begin
            if (diff > cfg.rpm_deadband) begin
               cur_in = mapped_ff;
            end
            state_in = S_FREQ;
         end
         S_FREQ: begin
            freq_in  = freq_prod[FREQ_PROD_SHIFT +: FREQ_W];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in = 1'b1;
               out_rpm_in   = cur_ff;
               out_freq_in  = freq_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         filt_ff      <= '0;
         cur_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filt_ff      <= filt_in;
         cur_ff       <= cur_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff      <= sum_in;
      avg_ff      <= avg_in;
      prod_a_ff   <= prod_a_in;
      prod_b_ff   <= prod_b_in;
      num_ff      <= num_in;
      neg_ff      <= neg_in;
      mapped_ff   <= mapped_in;
      freq_ff     <= freq_in;
      out_rpm_ff  <= out_rpm_in;
      out_freq_ff <= out_freq_in;
   end

endmodule

@@ rtl/pot_to_rpm_setpoint_filter_core.sv @@
// ----------------------------------------------------------------------------
// pot_to_rpm_setpoint_filter_core
// Potentiometer samples in, filtered rpm setpoint and frequency out.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while req_stall is low and summed in
// blocks of SAMPLE_COUNT; each completed block yields one item with the rpm
// setpoint and rpm/60 in Q.8. A two-entry queue holds block sums while the
// back end works, so req_stall rises only on the last sample of a block
// when that queue is full. The back end runs a block through up to nine steps
// (queue pop, block average, snap test, smoothing, level, divider start,
// hysteresis, rpm/60, output) plus a wait on the radix-2 divider for the
// linear rpm mapping; block average and rpm/60 use reciprocal multiplication.
// A block whose level falls in the deadzone skips the divider and the
// hysteresis. When blocks arrive faster than the back end finishes them, the
// input is held to one block per back end pass. The result sits in an output
// register until taken while the next block is already being worked on.
// Configuration registers are written through csr_we/csr_index/csr_data.
// ----------------------------------------------------------------------------
module pot_to_rpm_setpoint_filter_core
   import pfs_pkg::*;
#(
   parameter int SAMPLE_COUNT = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ADC_W-1:0]      req_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [RPM_W-1:0]      rsp_rpm,
   output logic [FREQ_W-1:0]     rsp_frequency_q8,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int SUM_W = $clog2(SAMPLE_COUNT * 4095 + 1);

   cfg_type          cfg_ff, cfg_in;
   logic             q_push;
   logic [SUM_W-1:0] q_push_data;
   logic             q_pop;
   logic [SUM_W-1:0] q_pop_data;
   logic             q_full;
   logic             q_empty;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_index))
            REG_DEADZONE:        cfg_in.deadzone        = csr_data[ADC_W-1:0];
            REG_ZERO_SNAP:       cfg_in.zero_snap       = csr_data[ADC_W-1:0];
            REG_SMOOTHING_ALPHA: cfg_in.smoothing_alpha = csr_data[ALPHA_W-1:0];
            REG_ADC_FULL_SCALE:  cfg_in.adc_full_scale  = csr_data[ADC_W-1:0];
            REG_MIN_RPM:         cfg_in.min_rpm         = csr_data[RPM_W-1:0];
            REG_MAX_RPM:         cfg_in.max_rpm         = csr_data[RPM_W-1:0];
            REG_RPM_DEADBAND:    cfg_in.rpm_deadband    = csr_data[RPM_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   pfs_front #(
      .SAMPLE_COUNT (SAMPLE_COUNT),
      .SUM_W        (SUM_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .push       (q_push),
      .push_data  (q_push_data),
      .full       (q_full)
   );

   pfs_fifo #(
      .WIDTH (SUM_W)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   pfs_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   pfs_back #(
      .SAMPLE_COUNT (SAMPLE_COUNT),
      .SUM_W        (SUM_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_data           (q_pop_data),
      .q_empty          (q_empty),
      .q_pop            (q_pop),
      .div_req          (div_req),
      .div_rsp          (div_rsp),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_rpm          (rsp_rpm),
      .rsp_frequency_q8 (rsp_frequency_q8)
   );

endmodule

@@ tb/sv/tb_pot_to_rpm_setpoint_filter_core.sv @@
// ----------------------------------------------------------------------------
// tb_pot_to_rpm_setpoint_filter_core
// Self-checking testbench for the potentiometer to rpm setpoint filter.
// ----------------------------------------------------------------------------
// Streams ADC samples into the core in whole blocks, mostly slow-moving levels
// with some noise and runs of zero, under a series of register settings that
// include the extremes: zero deadzone and snap, full deadzone, frozen and
// instant smoothing, degenerate scale, inverted rpm limits and wide
// hysteresis. A behavioral model of the averaging, smoothing, mapping and
// hysteresis predicts every setpoint, which is compared field by field with
// what the core delivers. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_pot_to_rpm_setpoint_filter_core;
   import pfs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLES_PER_BLOCK  = 16;
   localparam int SECONDS_PER_MINUTE = 60;
   localparam int IDLE_PAUSE         = 200;
   localparam int WATCHDOG_LIMIT     = 5000;
   localparam int REPORT_LIMIT       = 10;

   typedef struct {
      logic [RPM_W-1:0]  rpm;
      logic [FREQ_W-1:0] freq_q8;
   } setpoint_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [ADC_W-1:0]      req_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [RPM_W-1:0]      rsp_rpm;
   logic [FREQ_W-1:0]     rsp_frequency_q8;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // shadow of the core's registers and state
   cfg_type          shadow_cfg = CFG_RESET;
   int unsigned      block_sum = 0;
   int unsigned      block_fill = 0;
   logic [19:0]      ema_level = '0;
   logic [RPM_W-1:0] held_rpm = '0;

   logic [ADC_W-1:0] sample_fifo[$];
   setpoint_type     pending_setpoints[$];

   int samples_queued = 0;
   int samples_sent = 0;
   int setpoints_checked = 0;
   int settings_applied = 0;
   int failures = 0;
   int send_gap = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   bit sender_eager = 1'b0;
   bit receiver_eager = 1'b0;

   pot_to_rpm_setpoint_filter_core #(
      .SAMPLE_COUNT(SAMPLES_PER_BLOCK)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_rpm          (rsp_rpm),
      .rsp_frequency_q8 (rsp_frequency_q8),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 20);
      return $urandom_range(40, 200);
   endfunction

   function automatic logic [RPM_W-1:0] map_to_rpm(input int lvl);
      longint lo, hi, num, den, x;
      if (shadow_cfg.adc_full_scale <= shadow_cfg.deadzone) return shadow_cfg.max_rpm;
      lo  = longint'(shadow_cfg.min_rpm);
      hi  = longint'(shadow_cfg.max_rpm);
      num = (longint'(lvl) - longint'(shadow_cfg.deadzone)) * (hi - lo);
      den = longint'(shadow_cfg.adc_full_scale) - longint'(shadow_cfg.deadzone);
      x   = num / den + lo;
      if (x < lo) x = lo;
      else if (x > hi) x = hi;
      return RPM_W'(x);
   endfunction

   // accumulate one sample; a completed block yields one setpoint
   function automatic void take_sample(input logic [ADC_W-1:0] s);
      int unsigned     avg;
      int unsigned     alpha;
      longint unsigned mix;
      int              lvl;
      logic [RPM_W-1:0] mapped;
      int unsigned     diff;
      setpoint_type    sp;
      block_sum  += s;
      block_fill += 1;
      if (block_fill < SAMPLES_PER_BLOCK) return;
      avg        = block_sum / SAMPLES_PER_BLOCK;
      block_sum  = 0;
      block_fill = 0;
      if (avg <= shadow_cfg.deadzone) avg = 0;
      if (avg == 0 && ema_level <= (longint'(shadow_cfg.zero_snap) << 8)) begin
         ema_level = '0;
      end else begin
         alpha = (shadow_cfg.smoothing_alpha > 9'd256) ? 256 : shadow_cfg.smoothing_alpha;
         mix = longint'(ema_level) * (256 - alpha) + longint'(avg) * 256 * alpha + 128;
         ema_level = 20'(mix >> 8);
      end
      lvl = (int'(ema_level) + 128) >> 8;
      if (lvl <= int'(shadow_cfg.deadzone)) begin
         held_rpm = '0;
      end else begin
         mapped = map_to_rpm(lvl);
         diff = (mapped > held_rpm) ? mapped - held_rpm : held_rpm - mapped;
         if (diff > shadow_cfg.rpm_deadband) held_rpm = mapped;
      end
      sp.rpm     = held_rpm;
      sp.freq_q8 = FREQ_W'((longint'(held_rpm) * 256) / SECONDS_PER_MINUTE);
      pending_setpoints.push_back(sp);
   endfunction

   function automatic void check_setpoint(input logic [RPM_W-1:0] rpm,
                                          input logic [FREQ_W-1:0] freq_q8);
      setpoint_type want;
      if (pending_setpoints.size() == 0) begin
         failures++;
         if (failures <= REPORT_LIMIT)
            $display("unexpected setpoint: rpm %0d freq_q8 %0d", rpm, freq_q8);
         return;
      end
      want = pending_setpoints.pop_front();
      setpoints_checked++;
      if (rpm !== want.rpm || freq_q8 !== want.freq_q8) begin
         failures++;
         if (failures <= REPORT_LIMIT)
            $display("setpoint %0d: rpm exp %0d got %0d, freq_q8 exp %0d got %0d",
                     setpoints_checked, want.rpm, rpm, want.freq_q8, freq_q8);
      end
   endfunction

   // sample driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            take_sample(req_sample);
            samples_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (sample_fifo.size() > 0) begin
               req_valid  <= 1'b1;
               req_sample <= sample_fifo.pop_front();
               send_gap = sender_eager ? 0 : idle_len();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // setpoint monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_setpoint(rsp_rpm, rsp_frequency_q8);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            hold_left = receiver_eager ? 0 : idle_len();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[pot_to_rpm_setpoint_filter_core] ERROR");
            $finish;
         end
      end
   end

   function automatic void queue_sample(input logic [ADC_W-1:0] s);
      sample_fifo.push_back(s);
      samples_queued++;
   endfunction

   function automatic logic [ADC_W-1:0] near(input int centre, input int spread);
      int v;
      v = centre + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return ADC_W'(v);
   endfunction

   function automatic int pick_target();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return 0;
      if (r == 3) return 4095;
      if (r == 4) return int'(near(int'(shadow_cfg.deadzone), 3));
      return $urandom_range(0, 4095);
   endfunction

   task automatic run_phase(input int blocks);
      int target;
      int spread;
      int noisy;
      sender_eager   = ($urandom_range(0, 3) == 0);
      receiver_eager = ($urandom_range(0, 3) == 0);
      target = pick_target();
      for (int b = 0; b < blocks; b++) begin
         if ($urandom_range(0, 9) < 3) target = pick_target();
         spread = (target == 0) ? 0 : $urandom_range(0, 40);
         noisy  = ($urandom_range(0, 9) == 0);
         for (int k = 0; k < SAMPLES_PER_BLOCK; k++)
            queue_sample(noisy ? ADC_W'($urandom_range(0, 4095)) : near(target, spread));
      end
   endtask

   task automatic drain();
      while (samples_sent < samples_queued || pending_setpoints.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_DEADZONE:        shadow_cfg.deadzone        = val[ADC_W-1:0];
         REG_ZERO_SNAP:       shadow_cfg.zero_snap       = val[ADC_W-1:0];
         REG_SMOOTHING_ALPHA: shadow_cfg.smoothing_alpha = val[ALPHA_W-1:0];
         REG_ADC_FULL_SCALE:  shadow_cfg.adc_full_scale  = val[ADC_W-1:0];
         REG_MIN_RPM:         shadow_cfg.min_rpm         = val;
         REG_MAX_RPM:         shadow_cfg.max_rpm         = val;
         REG_RPM_DEADBAND:    shadow_cfg.rpm_deadband    = val;
         default: ;
      endcase
   endtask

   task automatic configure(input int dz, input int zs, input int al, input int fs,
                            input int mn, input int mx, input int hy);
      drain();
      repeat (IDLE_PAUSE) @(posedge clock);
      write_reg(REG_DEADZONE,        CSR_DATA_W'(dz));
      write_reg(REG_ZERO_SNAP,       CSR_DATA_W'(zs));
      write_reg(REG_SMOOTHING_ALPHA, CSR_DATA_W'(al));
      write_reg(REG_ADC_FULL_SCALE,  CSR_DATA_W'(fs));
      write_reg(REG_MIN_RPM,         CSR_DATA_W'(mn));
      write_reg(REG_MAX_RPM,         CSR_DATA_W'(mx));
      write_reg(REG_RPM_DEADBAND,    CSR_DATA_W'(hy));
      settings_applied++;
   endtask

   initial begin
      int dz, zs, al, fs, mn, mx, hy;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // opening block: sample extremes and alternating bit patterns
      queue_sample(12'h000);
      queue_sample(12'hFFF);
      queue_sample(12'hAAA);
      queue_sample(12'h555);
      for (int k = 4; k < SAMPLES_PER_BLOCK; k++) queue_sample(12'hFFF);
      run_phase(6);

      // register extremes: no deadzone, no snap, instant filter, full rpm span
      configure(0, 0, 256, 4095, 0, 65535, 0);
      run_phase(6);
      // frozen filter, wide hysteresis
      configure(50, 5, 0, 4095, 0, 3000, 65535);
      run_phase(4);
      // alpha above one acts as one
      configure(100, 4095, 511, 4000, 500, 2500, 0);
      run_phase(4);
      // full scale equal to deadzone, then below it
      configure(2000, 20, 128, 2000, 100, 1500, 5);
      run_phase(4);
      configure(3000, 20, 200, 100, 100, 1500, 5);
      run_phase(4);
      // inverted rpm limits
      configure(50, 5, 128, 4095, 60000, 100, 0);
      run_phase(5);
      // everything inside the deadzone
      configure(4095, 4095, 1, 4095, 0, 65535, 0);
      run_phase(4);
      // tiny full scale: every level past the edge clamps high
      configure(0, 0, 256, 1, 1000, 65535, 1);
      run_phase(4);

      for (int p = 0; p < 4; p++) begin
         dz = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 300);
         zs = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 40);
         al = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 256);
         fs = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4095) : $urandom_range(dz, 4095);
         mn = $urandom_range(0, 65535);
         mx = $urandom_range(0, 65535);
         if (mn > mx && $urandom_range(0, 3) != 0) begin
            hy = mn;
            mn = mx;
            mx = hy;
         end
         hy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 50);
         configure(dz, zs, al, fs, mn, mx, hy);
         run_phase(4);
      end

      drain();
      repeat (IDLE_PAUSE) @(posedge clock);
      $display("%0d samples sent, %0d setpoints checked", samples_sent, setpoints_checked);
      $display("%0d register settings after reset, %0d failures", settings_applied, failures);
      if (failures == 0)
         $display("[pot_to_rpm_setpoint_filter_core] OK");
      else
         $display("[pot_to_rpm_setpoint_filter_core] ERROR");
      $finish;
   end

endmodule
